### hdl/mstp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Prim spanning tree engine.
// No dependencies; used by the controller, the datapath and the top level.

package mstp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 1024;
  localparam int WEIGHT_BITS  = 16;

  localparam int VTX_BITS   = $clog2(MAX_VERTICES);
  localparam int VCNT_BITS  = $clog2(MAX_VERTICES + 1);
  localparam int EADDR_BITS = $clog2(MAX_EDGES);
  localparam int FILL_BITS  = $clog2(MAX_EDGES + 1);
  localparam int KEY_BITS   = WEIGHT_BITS + 1;

  localparam int PACK_BITS   = 2 * VTX_BITS + WEIGHT_BITS;
  localparam int TDATA_BITS  = ((PACK_BITS + 7) / 8) * 8;
  localparam int OP_BITS     = 2;
  localparam int CFG_BITS    = 7;

  localparam logic [KEY_BITS-1:0] KEY_INF = KEY_BITS'(1) << WEIGHT_BITS;

  localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] w;
    logic [VTX_BITS-1:0]    dst;
    logic [VTX_BITS-1:0]    src;
  } edge_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_KEY_CHK,
    ST_EMIT_SCAN,
    ST_EMIT_LOAD,
    ST_EMIT_EMPTY
  } st_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_issue;
    logic pick;
    logic edge_issue;
    logic key_issue;
    logic edge_next;
    logic relax;
    logic emit_issue;
    logic emit_next;
    logic emit_load;
    logic empty_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               n_le1;
    logic               scan_end;
    logic               found;
    logic               edge_end;
    logic               edge_match;
    logic               rounds_done;
    logic               emit_end;
    logic               emit_hit;
    logic               any;
    logic               out_free;
  } dp_stat_t;

endpackage

### hdl/mstp_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the spanning tree engine.
// Depends on mstp_pkg; drives the datapath through command and status structs.

module mstp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mstp_pkg::dp_stat_t stat,
  output mstp_pkg::dp_cmd_t  cmd
);

  mstp_pkg::st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mstp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mstp_pkg::ST_IDLE: begin
        if (in_tvalid && stat.op == mstp_pkg::OP_RUN) begin
          state_nxt = stat.n_le1 ? mstp_pkg::ST_EMIT_SCAN : mstp_pkg::ST_SCAN;
        end
      end
      mstp_pkg::ST_SCAN: begin
        if (stat.scan_end) state_nxt = mstp_pkg::ST_PICK;
      end
      mstp_pkg::ST_PICK: begin
        state_nxt = stat.found ? mstp_pkg::ST_EDGE_RD : mstp_pkg::ST_EMIT_SCAN;
      end
      mstp_pkg::ST_EDGE_RD: begin
        if (!stat.edge_end) begin
          state_nxt = mstp_pkg::ST_EDGE_CHK;
        end else if (stat.rounds_done) begin
          state_nxt = mstp_pkg::ST_EMIT_SCAN;
        end else begin
          state_nxt = mstp_pkg::ST_SCAN;
        end
      end
      mstp_pkg::ST_EDGE_CHK: begin
        state_nxt = stat.edge_match ? mstp_pkg::ST_KEY_CHK : mstp_pkg::ST_EDGE_RD;
      end
      mstp_pkg::ST_KEY_CHK: begin
        state_nxt = mstp_pkg::ST_EDGE_RD;
      end
      mstp_pkg::ST_EMIT_SCAN: begin
        if (stat.emit_end) begin
          state_nxt = stat.any ? mstp_pkg::ST_IDLE : mstp_pkg::ST_EMIT_EMPTY;
        end else if (stat.emit_hit) begin
          state_nxt = mstp_pkg::ST_EMIT_LOAD;
        end
      end
      mstp_pkg::ST_EMIT_LOAD: begin
        if (stat.out_free) state_nxt = mstp_pkg::ST_EMIT_SCAN;
      end
      mstp_pkg::ST_EMIT_EMPTY: begin
        if (stat.out_free) state_nxt = mstp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mstp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      mstp_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      mstp_pkg::ST_SCAN: begin
        cmd.scan_issue = !stat.scan_end;
      end
      mstp_pkg::ST_PICK: begin
        cmd.pick = stat.found;
      end
      mstp_pkg::ST_EDGE_RD: begin
        cmd.edge_issue = !stat.edge_end;
        cmd.scan_start = stat.edge_end && !stat.rounds_done;
      end
      mstp_pkg::ST_EDGE_CHK: begin
        cmd.key_issue = stat.edge_match;
        cmd.edge_next = !stat.edge_match;
      end
      mstp_pkg::ST_KEY_CHK: begin
        cmd.relax     = 1'b1;
        cmd.edge_next = 1'b1;
      end
      mstp_pkg::ST_EMIT_SCAN: begin
        cmd.emit_issue = !stat.emit_end && stat.emit_hit;
        cmd.emit_next  = !stat.emit_end && !stat.emit_hit;
      end
      mstp_pkg::ST_EMIT_LOAD: begin
        cmd.emit_load = stat.out_free;
      end
      mstp_pkg::ST_EMIT_EMPTY: begin
        cmd.empty_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/mstp_datapath.sv
`timescale 1ns / 1ps
// Datapath of the spanning tree engine: edge store, key and parent memories,
// tree and reach bit vectors, scan counters and the result register. Uses mstp_pkg.

module mstp_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mstp_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic [mstp_pkg::TDATA_BITS-1:0]   in_tdata,
  input  logic [mstp_pkg::OP_BITS-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mstp_pkg::TDATA_BITS-1:0]   out_tdata,
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  input  mstp_pkg::dp_cmd_t                 cmd,
  output mstp_pkg::dp_stat_t                stat
);

  localparam int VB = mstp_pkg::VTX_BITS;
  localparam int CB = mstp_pkg::VCNT_BITS;
  localparam int WB = mstp_pkg::WEIGHT_BITS;
  localparam int FB = mstp_pkg::FILL_BITS;
  localparam int NV = mstp_pkg::MAX_VERTICES;
  localparam logic [NV-1:0] ROOT_MASK = NV'(1);

  mstp_pkg::edge_t edge_mem [mstp_pkg::MAX_EDGES];
  logic [WB-1:0]   key_mem  [NV];
  logic [VB-1:0]   par_mem  [NV];

  localparam int CFG_BITS_L = mstp_pkg::CFG_BITS;
  logic [CFG_BITS_L-1:0] vcount_r;
  logic [CB-1:0]   n_eff;
  logic [FB-1:0]   fill_r;
  logic            drop_r;
  logic [NV-1:0]   in_tree_r;
  logic [NV-1:0]   pv_r;
  logic [NV-1:0]   reached;
  logic [CB-1:0]   scan_idx_r;
  logic [VB-1:0]   scan_d_r;
  logic            scan_vld_r;
  logic [mstp_pkg::KEY_BITS-1:0] best_r;
  logic [VB-1:0]   u_r;
  logic            found_r;
  logic [CB-1:0]   round_r;
  logic [FB-1:0]   edge_idx_r;
  mstp_pkg::edge_t edge_q_r;
  logic [WB-1:0]   key_q_r;
  logic [VB-1:0]   par_q_r;
  logic [CB-1:0]   emit_idx_r;
  logic            any_r;
  logic            out_valid_r;
  logic [VB-1:0]   out_par_r;
  logic [VB-1:0]   out_child_r;
  logic [WB-1:0]   out_w_r;
  logic            out_has_r;
  logic            out_drop_r;
  logic            out_last_r;

  mstp_pkg::edge_t in_entry;
  logic            is_load;
  logic            is_run;
  logic            is_clear;
  logic            drop;
  logic            cand;
  logic            key_better;
  logic            relax_wr;
  logic            more;
  logic            out_free;
  logic            key_re;
  logic [VB-1:0]   key_ra;

  assign cfg_ready = 1'b1;
  assign n_eff = (vcount_r > CFG_BITS_L'(NV)) ? CB'(NV) : CB'(vcount_r);

  assign in_entry.src = in_tdata[VB-1:0];
  assign in_entry.dst = in_tdata[2*VB-1:VB];
  assign in_entry.w   = in_tdata[2*VB+WB-1:2*VB];

  assign is_load  = cmd.accept && (in_tuser == mstp_pkg::OP_LOAD);
  assign is_run   = cmd.accept && (in_tuser == mstp_pkg::OP_RUN);
  assign is_clear = cmd.accept && (in_tuser == mstp_pkg::OP_CLEAR);
  assign drop = (fill_r >= FB'(mstp_pkg::MAX_EDGES)) ||
                (CB'(in_entry.src) >= n_eff) || (CB'(in_entry.dst) >= n_eff);

  assign reached = pv_r | ROOT_MASK;
  assign cand = scan_vld_r && !in_tree_r[scan_d_r] && reached[scan_d_r] &&
                ({1'b0, key_q_r} < best_r);
  assign key_better = !reached[edge_q_r.dst] || (edge_q_r.w < key_q_r);
  assign relax_wr = cmd.relax && key_better;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    more = 1'b0;
    for (int j = 0; j < NV; j++) begin
      if (CB'(j) > emit_idx_r && CB'(j) < n_eff && pv_r[j]) more = 1'b1;
    end
  end

  always_comb begin
    key_re = cmd.scan_issue || cmd.key_issue || cmd.emit_issue;
    if (cmd.scan_issue) begin
      key_ra = scan_idx_r[VB-1:0];
    end else if (cmd.key_issue) begin
      key_ra = edge_q_r.dst;
    end else begin
      key_ra = emit_idx_r[VB-1:0];
    end
  end

  always_comb begin
    stat.op          = in_tuser;
    stat.n_le1       = n_eff <= CB'(1);
    stat.scan_end    = scan_idx_r == n_eff;
    stat.found       = found_r;
    stat.edge_end    = edge_idx_r >= fill_r;
    stat.edge_match  = (edge_q_r.src == u_r) && (CB'(edge_q_r.dst) < n_eff) &&
                       !in_tree_r[edge_q_r.dst];
    stat.rounds_done = round_r == (n_eff - CB'(1));
    stat.emit_end    = emit_idx_r >= n_eff;
    stat.emit_hit    = pv_r[emit_idx_r[VB-1:0]];
    stat.any         = any_r;
    stat.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (is_load && !drop) edge_mem[fill_r[mstp_pkg::EADDR_BITS-1:0]] <= in_entry;
    if (cmd.edge_issue) edge_q_r <= edge_mem[edge_idx_r[mstp_pkg::EADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (is_run) begin
      key_mem[0] <= '0;
    end else if (relax_wr) begin
      key_mem[edge_q_r.dst] <= edge_q_r.w;
    end
    if (key_re) key_q_r <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (relax_wr) par_mem[edge_q_r.dst] <= u_r;
    if (cmd.emit_issue) par_q_r <= par_mem[emit_idx_r[VB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= CFG_BITS_L'(NV);
      fill_r      <= '0;
      drop_r      <= 1'b0;
      scan_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) vcount_r <= cfg_data;
      if (is_clear) begin
        fill_r <= '0;
        drop_r <= 1'b0;
      end else if (is_load) begin
        if (drop) begin
          drop_r <= 1'b1;
        end else begin
          fill_r <= fill_r + FB'(1);
        end
      end
      scan_vld_r <= cmd.scan_issue;
      if (cmd.emit_load || cmd.empty_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_run) begin
      in_tree_r  <= '0;
      pv_r       <= '0;
      round_r    <= '0;
      emit_idx_r <= CB'(1);
      any_r      <= 1'b0;
    end else begin
      if (cmd.pick) begin
        in_tree_r[u_r] <= 1'b1;
        round_r        <= round_r + CB'(1);
      end
      if (relax_wr) pv_r[edge_q_r.dst] <= 1'b1;
      if (cmd.emit_next || cmd.emit_load) emit_idx_r <= emit_idx_r + CB'(1);
      if (cmd.emit_load) any_r <= 1'b1;
    end
    if (is_run || cmd.scan_start) begin
      scan_idx_r <= '0;
      best_r     <= mstp_pkg::KEY_INF;
      found_r    <= 1'b0;
    end else begin
      if (cmd.scan_issue) begin
        scan_idx_r <= scan_idx_r + CB'(1);
        scan_d_r   <= scan_idx_r[VB-1:0];
      end
      if (cand) begin
        best_r  <= {1'b0, key_q_r};
        u_r     <= scan_d_r;
        found_r <= 1'b1;
      end
    end
    if (cmd.pick) begin
      edge_idx_r <= '0;
    end else if (cmd.edge_next) begin
      edge_idx_r <= edge_idx_r + FB'(1);
    end
    if (cmd.emit_load) begin
      out_par_r   <= par_q_r;
      out_child_r <= emit_idx_r[VB-1:0];
      out_w_r     <= key_q_r;
      out_has_r   <= 1'b1;
      out_drop_r  <= drop_r;
      out_last_r  <= !more;
    end else if (cmd.empty_load) begin
      out_par_r   <= '0;
      out_child_r <= '0;
      out_w_r     <= '0;
      out_has_r   <= 1'b0;
      out_drop_r  <= drop_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mstp_pkg::TDATA_BITS'({out_w_r, out_child_r, out_par_r});
  assign out_tuser  = {out_drop_r, out_has_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |-> found_r)
    else $error("vertex picked without a candidate");
  a_pick_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |=> in_tree_r[$past(u_r)])
    else $error("picked vertex not marked in tree");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load || cmd.empty_load) |-> out_free)
    else $error("result register overwritten");
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FB'(mstp_pkg::MAX_EDGES))
    else $error("edge fill beyond capacity");
`endif

endmodule

### hdl/minimum_spanning_tree_prim.sv
`timescale 1ns / 1ps
// Load, clear and unused-opcode transfers are accepted back to back.
// A run holds off the input: each round scans the keys and picks a vertex, then reads every
// stored edge and checks the key of each edge from that vertex to one outside the tree;
// then it walks vertices 1..n-1 and sends one result per reached vertex, stalled by out_tready.
// Synchronous reset (rst_n low) empties the edge store and the drop flag and sets
// vertex_count to 64; edge memory contents are kept. Uses mstp_pkg, mstp_ctrl, mstp_datapath.

module minimum_spanning_tree_prim (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mstp_pkg::CFG_BITS-1:0]   cfg_data,    // vertex_count
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mstp_pkg::TDATA_BITS-1:0] in_tdata,    // source_vertex, dest_vertex, edge_weight
  input  logic [mstp_pkg::OP_BITS-1:0]    in_tuser,    // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mstp_pkg::TDATA_BITS-1:0] out_tdata,   // parent_vertex, child_vertex, tree_weight
  output logic [1:0]                      out_tuser,   // has_edge, entries_dropped
  output logic                            out_tlast
);

  mstp_pkg::dp_cmd_t  cmd;
  mstp_pkg::dp_stat_t stat;

  mstp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mstp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
